@@ design/i2cbm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C byte master package
// Command codes, register indexes, phase encoding and shared types.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_BIT_HOLD   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COND_HOLD  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_POLL_LIMIT = 2'd2;

    localparam logic [7:0] BIT_HOLD_RESET   = 8'd2;
    localparam logic [7:0] COND_HOLD_RESET  = 8'd5;
    localparam logic [7:0] POLL_LIMIT_RESET = 8'd50;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE, PH_S1, PH_S2, PH_S3, PH_P1, PH_P2, PH_P3,
        PH_WL, PH_WH, PH_AL, PH_AW, PH_AK,
        PH_RL, PH_RH, PH_KL, PH_KH
    } phase_t;

    typedef struct packed {
        logic [7:0] bit_hold;
        logic [7:0] cond_hold;
        logic [7:0] poll_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] write_byte;
        logic       last_read;
        logic       sda_level;
    } tick_t;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_error;
    } result_t;

    // A hold count of zero acts as one tick.
    function automatic logic [7:0] hold_of(input logic [7:0] r);
        hold_of = (r == 8'd0) ? 8'd1 : r;
    endfunction

endpackage
`default_nettype wire

@@ design/i2cbm_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C byte master tick channel
// Valid/ready channel carrying one bus tick: command, data and sampled SDA.
// ----------------------------------------------------------------------------
interface i2cbm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] write_byte;
    logic       last_read;
    logic       sda_level;

    modport source (output valid, output command, output write_byte,
                    output last_read, output sda_level, input ready);
    modport sink   (input valid, input command, input write_byte,
                    input last_read, input sda_level, output ready);
endinterface
`default_nettype wire

@@ design/i2cbm_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C byte master result channel
// Valid/ready channel carrying line levels and status for one tick.
// ----------------------------------------------------------------------------
interface i2cbm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_error;

    modport source (output valid, output scl_release, output sda_release,
                    output busy_res, output done_res, output read_byte,
                    output ack_error, input ready);
    modport sink   (input valid, input scl_release, input sda_release,
                    input busy_res, input done_res, input read_byte,
                    input ack_error, output ready);
endinterface
`default_nettype wire

@@ design/i2cbm_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C byte master configuration registers
// Hold counts and ack poll limit, written through a plain write port.
// ----------------------------------------------------------------------------
module i2cbm_cfg
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 wr_en,
    input  wire [i2cbm_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  wire [i2cbm_pkg::CFG_DATA_W-1:0]     wr_data,
    output i2cbm_pkg::cfg_t                     cfg
);

    i2cbm_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_hold   <= i2cbm_pkg::BIT_HOLD_RESET;
            cfg_reg.cond_hold  <= i2cbm_pkg::COND_HOLD_RESET;
            cfg_reg.poll_limit <= i2cbm_pkg::POLL_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                i2cbm_pkg::REG_BIT_HOLD:   cfg_reg.bit_hold   <= wr_data;
                i2cbm_pkg::REG_COND_HOLD:  cfg_reg.cond_hold  <= wr_data;
                i2cbm_pkg::REG_POLL_LIMIT: cfg_reg.poll_limit <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ design/i2cbm_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C byte master sequencer
// Phase state machine advanced once per tick; produces that tick's result.
// ----------------------------------------------------------------------------
module i2cbm_core
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 step,
    input  i2cbm_pkg::tick_t    tick,
    input  i2cbm_pkg::cfg_t     cfg,
    output i2cbm_pkg::result_t  result
);

    i2cbm_pkg::phase_t phase_reg, phase_next;
    logic [7:0] hold_count_reg, hold_count_next;
    logic [2:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_data_reg, shift_data_next;
    logic [7:0] poll_count_reg, poll_count_next;
    logic       nack_pending_reg, nack_pending_next;
    logic       error_flag_reg, error_flag_next;
    logic [7:0] read_hold_reg, read_hold_next;
    logic       idle_scl_reg, idle_scl_next;
    logic       idle_sda_reg, idle_sda_next;

    logic [8:0] hold_sum;
    logic       bit_over;
    logic       cond_over;
    logic       done;
    logic       scl;
    logic       sda;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= i2cbm_pkg::PH_IDLE;
            hold_count_reg   <= '0;
            bit_index_reg    <= '0;
            shift_data_reg   <= '0;
            poll_count_reg   <= '0;
            nack_pending_reg <= 1'b0;
            error_flag_reg   <= 1'b0;
            read_hold_reg    <= '0;
            idle_scl_reg     <= 1'b1;
            idle_sda_reg     <= 1'b1;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            hold_count_reg   <= hold_count_next;
            bit_index_reg    <= bit_index_next;
            shift_data_reg   <= shift_data_next;
            poll_count_reg   <= poll_count_next;
            nack_pending_reg <= nack_pending_next;
            error_flag_reg   <= error_flag_next;
            read_hold_reg    <= read_hold_next;
            idle_scl_reg     <= idle_scl_next;
            idle_sda_reg     <= idle_sda_next;
        end
    end

    assign hold_sum  = {1'b0, hold_count_reg} + 9'd1;
    assign bit_over  = hold_sum >= {1'b0, i2cbm_pkg::hold_of(cfg.bit_hold)};
    assign cond_over = hold_sum >= {1'b0, i2cbm_pkg::hold_of(cfg.cond_hold)};

    always_comb
    begin
        phase_next        = phase_reg;
        hold_count_next   = hold_count_reg;
        bit_index_next    = bit_index_reg;
        shift_data_next   = shift_data_reg;
        poll_count_next   = poll_count_reg;
        nack_pending_next = nack_pending_reg;
        error_flag_next   = error_flag_reg;
        read_hold_next    = read_hold_reg;
        idle_scl_next     = idle_scl_reg;
        idle_sda_next     = idle_sda_reg;
        done              = 1'b0;
        scl               = 1'b1;
        sda               = 1'b1;

        case (phase_reg)
            i2cbm_pkg::PH_IDLE:
            begin
                hold_count_next = '0;
                case (tick.command)
                    i2cbm_pkg::CMD_START: phase_next = i2cbm_pkg::PH_S1;
                    i2cbm_pkg::CMD_STOP:  phase_next = i2cbm_pkg::PH_P1;
                    i2cbm_pkg::CMD_WRITE:
                    begin
                        shift_data_next = tick.write_byte;
                        bit_index_next  = '0;
                        error_flag_next = 1'b0;
                        phase_next      = i2cbm_pkg::PH_WL;
                    end
                    i2cbm_pkg::CMD_READ:
                    begin
                        shift_data_next   = '0;
                        bit_index_next    = '0;
                        nack_pending_next = tick.last_read;
                        phase_next        = i2cbm_pkg::PH_RL;
                    end
                    default: ;
                endcase
            end
            i2cbm_pkg::PH_S1, i2cbm_pkg::PH_S2, i2cbm_pkg::PH_S3,
            i2cbm_pkg::PH_P1, i2cbm_pkg::PH_P2, i2cbm_pkg::PH_P3:
            begin
                if (cond_over)
                begin
                    hold_count_next = '0;
                    case (phase_reg)
                        i2cbm_pkg::PH_S1: phase_next = i2cbm_pkg::PH_S2;
                        i2cbm_pkg::PH_S2: phase_next = i2cbm_pkg::PH_S3;
                        i2cbm_pkg::PH_P1: phase_next = i2cbm_pkg::PH_P2;
                        i2cbm_pkg::PH_P2: phase_next = i2cbm_pkg::PH_P3;
                        i2cbm_pkg::PH_S3:
                        begin
                            phase_next    = i2cbm_pkg::PH_IDLE;
                            idle_scl_next = 1'b0;
                            idle_sda_next = 1'b0;
                            done          = 1'b1;
                        end
                        default:
                        begin
                            phase_next    = i2cbm_pkg::PH_IDLE;
                            idle_scl_next = 1'b1;
                            idle_sda_next = 1'b1;
                            done          = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    hold_count_next = hold_sum[7:0];
                end
            end
            i2cbm_pkg::PH_AW:
            begin
                if (!tick.sda_level)
                begin
                    phase_next      = i2cbm_pkg::PH_AK;
                    hold_count_next = '0;
                end
                else if (poll_count_reg >= cfg.poll_limit)
                begin
                    // no ack in time: flag it and release the bus with a stop
                    error_flag_next = 1'b1;
                    phase_next      = i2cbm_pkg::PH_P1;
                    hold_count_next = '0;
                end
                else
                begin
                    poll_count_next = poll_count_reg + 8'd1;
                end
            end
            default:
            begin
                // data and ack bit phases run on the bit hold count
                if (bit_over)
                begin
                    hold_count_next = '0;
                    case (phase_reg)
                        i2cbm_pkg::PH_WL: phase_next = i2cbm_pkg::PH_WH;
                        i2cbm_pkg::PH_WH:
                        begin
                            if (bit_index_reg == i2cbm_pkg::LAST_BIT)
                            begin
                                phase_next = i2cbm_pkg::PH_AL;
                            end
                            else
                            begin
                                bit_index_next  = bit_index_reg + 3'd1;
                                shift_data_next = {shift_data_reg[6:0], 1'b0};
                                phase_next      = i2cbm_pkg::PH_WL;
                            end
                        end
                        i2cbm_pkg::PH_AL:
                        begin
                            poll_count_next = '0;
                            phase_next      = i2cbm_pkg::PH_AW;
                        end
                        i2cbm_pkg::PH_RL: phase_next = i2cbm_pkg::PH_RH;
                        i2cbm_pkg::PH_RH:
                        begin
                            shift_data_next = {shift_data_reg[6:0], tick.sda_level};
                            if (bit_index_reg == i2cbm_pkg::LAST_BIT)
                            begin
                                read_hold_next = {shift_data_reg[6:0], tick.sda_level};
                                phase_next     = i2cbm_pkg::PH_KL;
                            end
                            else
                            begin
                                bit_index_next = bit_index_reg + 3'd1;
                                phase_next     = i2cbm_pkg::PH_RL;
                            end
                        end
                        i2cbm_pkg::PH_KL: phase_next = i2cbm_pkg::PH_KH;
                        default:
                        begin
                            // ack received or ack/nack sent: SCL low, SDA released
                            phase_next    = i2cbm_pkg::PH_IDLE;
                            idle_scl_next = 1'b0;
                            idle_sda_next = 1'b1;
                            done          = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    hold_count_next = hold_sum[7:0];
                end
            end
        endcase

        // line levels follow the phase after this tick's update
        case (phase_next)
            i2cbm_pkg::PH_IDLE: begin scl = idle_scl_next; sda = idle_sda_next; end
            i2cbm_pkg::PH_S1:   begin scl = idle_scl_next; sda = 1'b1; end
            i2cbm_pkg::PH_S2:   begin scl = 1'b1; sda = 1'b1; end
            i2cbm_pkg::PH_S3:   begin scl = 1'b1; sda = 1'b0; end
            i2cbm_pkg::PH_P1:   begin scl = 1'b0; sda = 1'b0; end
            i2cbm_pkg::PH_P2:   begin scl = 1'b1; sda = 1'b0; end
            i2cbm_pkg::PH_P3:   begin scl = 1'b1; sda = 1'b1; end
            i2cbm_pkg::PH_WL:   begin scl = 1'b0; sda = shift_data_next[7]; end
            i2cbm_pkg::PH_WH:   begin scl = 1'b1; sda = shift_data_next[7]; end
            i2cbm_pkg::PH_AL:   begin scl = 1'b0; sda = 1'b1; end
            i2cbm_pkg::PH_RL:   begin scl = 1'b0; sda = 1'b1; end
            i2cbm_pkg::PH_KL:   begin scl = 1'b0; sda = nack_pending_next; end
            i2cbm_pkg::PH_KH:   begin scl = 1'b1; sda = nack_pending_next; end
            default:            begin scl = 1'b1; sda = 1'b1; end
        endcase
    end

    assign result.scl_release = scl;
    assign result.sda_release = sda;
    assign result.busy_res    = (phase_next != i2cbm_pkg::PH_IDLE);
    assign result.done_res    = done;
    assign result.read_byte   = read_hold_next;
    assign result.ack_error   = error_flag_next;

endmodule
`default_nettype wire

@@ design/i2c_byte_master_with_ack_timeout.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C byte master with ack timeout
// Open-drain I2C sequencer: start, stop, write byte with ack poll, read byte.
// Results: a tick's result is valid once the tick has passed the tick
//   register and then the result register.
// Throughput: one tick per cycle unless the result side stalls; the phase
//   machine advances whenever the held tick moves into the result register.
// Reset: idle, both lines released, registers at 2 / 5 / 50, no valid items.
// ----------------------------------------------------------------------------
module i2c_byte_master_with_ack_timeout
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    i2cbm_in_if.sink                            req,
    i2cbm_out_if.source                         rsp,
    input  wire                                 wr_en,
    input  wire [i2cbm_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  wire [i2cbm_pkg::CFG_DATA_W-1:0]     wr_data
);

    i2cbm_pkg::cfg_t    cfg;
    i2cbm_pkg::tick_t   tick_reg;
    i2cbm_pkg::result_t result;
    i2cbm_pkg::result_t result_reg;
    logic               tick_valid_reg;
    logic               rsp_valid_reg;
    logic               advance;

    // move the held tick into the result register when that has room
    assign advance   = tick_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !tick_valid_reg || advance;

    i2cbm_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    i2cbm_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .tick   (tick_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                tick_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            tick_reg.command    <= req.command;
            tick_reg.write_byte <= req.write_byte;
            tick_reg.last_read  <= req.last_read;
            tick_reg.sda_level  <= req.sda_level;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.scl_release = result_reg.scl_release;
    assign rsp.sda_release = result_reg.sda_release;
    assign rsp.busy_res    = result_reg.busy_res;
    assign rsp.done_res    = result_reg.done_res;
    assign rsp.read_byte   = result_reg.read_byte;
    assign rsp.ack_error   = result_reg.ack_error;

endmodule
`default_nettype wire
